// ===== hw/rtl/dcftx_pkg.sv =====
`timescale 1ns / 1ps

package dcftx_pkg;

  // Default width of byte sizes, offsets and thresholds.
  localparam int unsigned SIZE_BITS_DEF = 12;

  // Retry counters and their limits.
  localparam int unsigned RETRY_W = 9;
  localparam int unsigned LIMIT_W = 8;
  localparam logic [RETRY_W-1:0] RETRY_TOP = '1;

  // Register reset values.
  localparam logic [11:0] RST_THRESHOLD = 12'd4095;
  localparam logic [LIMIT_W-1:0] RST_MAX_SHORT = 8'd7;
  localparam logic [LIMIT_W-1:0] RST_MAX_LONG = 8'd4;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACCESS    = 3'd0,
    CMD_GOT_CTS   = 3'd1,
    CMD_MISS_CTS  = 3'd2,
    CMD_GOT_ACK   = 3'd3,
    CMD_MISS_ACK  = 3'd4,
    CMD_NEXT_FRAG = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RTS_THR   = 2'd0,
    CFG_FRAG_THR  = 2'd1,
    CFG_MAX_SHORT = 2'd2,
    CFG_MAX_LONG  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WIN_NONE  = 2'd0,
    WIN_RESET = 2'd1,
    WIN_GROW  = 2'd2
  } win_e;

  typedef enum logic [1:0] {
    RPT_NONE  = 2'd0,
    RPT_OK    = 2'd1,
    RPT_RETRY = 2'd2,
    RPT_DROP  = 2'd3
  } rpt_e;

  // Microcode program counter and its steps.
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_DEQ    = 3'd1;
  localparam step_t ST_DINIT  = 3'd2;
  localparam step_t ST_DITER  = 3'd3;
  localparam step_t ST_DECIDE = 3'd4;
  localparam step_t ST_EMIT   = 3'd5;

  // Condition under which a step repeats instead of moving on.
  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_DIV  = 2'd2,
    HOLD_OUT  = 2'd3
  } hold_e;

  typedef struct packed {
    hold_e hold;
    logic  jump;
    step_t target;
    logic  deq;
    logic  div_init;
    logic  div_step;
    logic  decide;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic out_busy;
  } seq_stat_t;

endpackage

// ===== hw/rtl/dcftx_seq.sv =====
`timescale 1ns / 1ps

module dcftx_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcftx_pkg::seq_stat_t stat_i,
  output dcftx_pkg::uword_t    ctrl_o,
  output logic                 in_ready_o
);
  import dcftx_pkg::*;

  step_t  pc_q, pc_d;
  uword_t uw;
  logic   held;

  // Control store: one word per step.
  function automatic uword_t rom(input step_t s);
    uword_t w;
    w = '0;
    case (s)
      ST_IDLE:   w.hold = HOLD_IN;
      ST_DEQ:    w.deq = 1'b1;
      ST_DINIT:  w.div_init = 1'b1;
      ST_DITER: begin
        w.div_step = 1'b1;
        w.hold     = HOLD_DIV;
      end
      ST_DECIDE: w.decide = 1'b1;
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.hold   = HOLD_OUT;
        w.jump   = 1'b1;
        w.target = ST_IDLE;
      end
      default: begin
        w.jump   = 1'b1;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  assign uw = rom(pc_q);

  always_comb begin
    case (uw.hold)
      HOLD_IN:  held = !stat_i.in_fire;
      HOLD_DIV: held = !stat_i.div_last;
      HOLD_OUT: held = stat_i.out_busy;
      default:  held = 1'b0;
    endcase
    if (held) begin
      pc_d = pc_q;
    end else if (uw.jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o     = uw;
  assign in_ready_o = (uw.hold == HOLD_IN);

endmodule

// ===== hw/rtl/dcftx_div.sv =====
`timescale 1ns / 1ps

module dcftx_div #(
  parameter int unsigned SIZE_BITS = dcftx_pkg::SIZE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 init_i,
  input  logic                 step_i,
  input  logic [SIZE_BITS-1:0] dividend_i,
  input  logic [SIZE_BITS-1:0] divisor_i,
  output logic [SIZE_BITS-1:0] quo_o,
  output logic [SIZE_BITS-1:0] rem_o,
  output logic                 last_o
);
  localparam int unsigned CntW = $clog2(SIZE_BITS + 1);

  logic [SIZE_BITS-1:0] quo_q, rem_q, dvs_q;
  logic [CntW-1:0]      cnt_q;
  logic [SIZE_BITS:0]   shifted;
  logic                 ge;

  // Restoring division, one quotient bit per step, MSB first.
  assign shifted = {rem_q, quo_q[SIZE_BITS-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (init_i) begin
      cnt_q <= CntW'(SIZE_BITS);
    end else if (step_i && cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= {quo_q[SIZE_BITS-2:0], ge};
      rem_q <= ge ? SIZE_BITS'(shifted - {1'b0, dvs_q}) : shifted[SIZE_BITS-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign last_o = (cnt_q == CntW'(1));

endmodule

// ===== hw/rtl/dcftx_dp.sv =====
`timescale 1ns / 1ps

module dcftx_dp #(
  parameter int unsigned SIZE_BITS = dcftx_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dcftx_pkg::uword_t                 ctrl_i,
  input  logic                              in_fire_i,
  input  logic [dcftx_pkg::CMD_W-1:0]       in_cmd_i,
  input  logic                              in_qempty_i,
  input  logic [SIZE_BITS-1:0]              in_psize_i,
  input  logic                              in_bcast_i,
  input  logic                              cfg_we_i,
  input  dcftx_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [SIZE_BITS-1:0]              cfg_data_i,
  input  logic [SIZE_BITS-1:0]              div_quo_i,
  input  logic [SIZE_BITS-1:0]              div_rem_i,
  output logic [SIZE_BITS-1:0]              div_dividend_o,
  output logic [SIZE_BITS-1:0]              div_divisor_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_busy_o,
  output logic                              tx_start_o,
  output logic [SIZE_BITS-1:0]              tx_offset_o,
  output logic [SIZE_BITS-1:0]              tx_length_o,
  output logic [SIZE_BITS-1:0]              frag_index_o,
  output logic                              more_frags_o,
  output logic                              use_rts_o,
  output logic                              want_ack_o,
  output logic [SIZE_BITS-1:0]              next_frag_len_o,
  output logic                              dequeue_o,
  output dcftx_pkg::win_e                   window_action_o,
  output dcftx_pkg::rpt_e                   report_o,
  output logic                              holding_packet_o
);
  import dcftx_pkg::*;

  localparam int unsigned NW = SIZE_BITS + 1;
  localparam int unsigned PW = 2 * SIZE_BITS;

  // Configuration registers.
  logic [SIZE_BITS-1:0] rts_thr_q, frag_thr_q;
  logic [LIMIT_W-1:0]   max_short_q, max_long_q;

  // Packet state.
  logic                 has_q, has_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 bcast_q, bcast_d;
  logic [SIZE_BITS-1:0] fc_q, fc_d;
  logic [RETRY_W-1:0]   src_q, src_d, lrc_q, lrc_d;

  // Captured event.
  logic [CMD_W-1:0]     cmd_q;
  logic                 qempty_q, pbcast_q;
  logic [SIZE_BITS-1:0] psize_q;

  // Decision results, held from the decide step to the emit step.
  logic                 deq_q, deq_d;
  logic                 send_q, send_d;
  logic                 start_q, start_d;
  logic [SIZE_BITS-1:0] len_q, len_d;
  logic                 rts_q, rts_d;
  logic                 ack_q, ack_d;
  win_e                 win_q, win_d;
  rpt_e                 rpt_q, rpt_d;
  logic [NW-1:0]        n_q;
  logic [SIZE_BITS-1:0] lastlen_q;

  // Output register.
  logic                 out_valid_q;
  logic                 o_start_q, o_more_q, o_rts_q, o_ack_q, o_deq_q, o_hold_q;
  logic [SIZE_BITS-1:0] o_off_q, o_len_q, o_idx_q, o_next_q;
  win_e                 o_win_q;
  rpt_e                 o_rpt_q;

  logic [SIZE_BITS-1:0] thr_eff;
  logic [NW-1:0]        n_w;
  logic [SIZE_BITS-1:0] lastlen_w;
  logic                 frag_w, last_w;
  logic [RETRY_W-1:0]   src_inc, lrc_inc;
  logic                 emit_fire;
  logic                 e_last;
  logic [PW-1:0]        prod;
  logic [SIZE_BITS-1:0] e_next;

  assign thr_eff   = (frag_thr_q == '0) ? SIZE_BITS'(1) : frag_thr_q;
  assign n_w       = {1'b0, div_quo_i} + NW'(div_rem_i != '0);
  assign lastlen_w = (div_rem_i != '0) ? div_rem_i : thr_eff;
  assign frag_w    = (size_q > thr_eff);
  assign last_w    = (({1'b0, fc_q} + NW'(1)) >= n_w);
  assign src_inc   = (src_q == RETRY_TOP) ? src_q : src_q + RETRY_W'(1);
  assign lrc_inc   = (lrc_q == RETRY_TOP) ? lrc_q : lrc_q + RETRY_W'(1);

  assign div_dividend_o = size_q;
  assign div_divisor_o  = thr_eff;

  always_comb begin
    has_d   = has_q;
    size_d  = size_q;
    bcast_d = bcast_q;
    fc_d    = fc_q;
    src_d   = src_q;
    lrc_d   = lrc_q;
    deq_d   = deq_q;
    send_d  = send_q;
    start_d = start_q;
    len_d   = len_q;
    rts_d   = rts_q;
    ack_d   = ack_q;
    win_d   = win_q;
    rpt_d   = rpt_q;
    if (ctrl_i.deq) begin
      deq_d = 1'b0;
      if (cmd_e'(cmd_q) == CMD_ACCESS && !has_q && !qempty_q) begin
        has_d   = 1'b1;
        size_d  = psize_q;
        bcast_d = pbcast_q;
        fc_d    = '0;
        src_d   = '0;
        lrc_d   = '0;
        deq_d   = 1'b1;
      end
    end
    if (ctrl_i.decide) begin
      send_d  = 1'b0;
      start_d = 1'b0;
      len_d   = '0;
      rts_d   = 1'b0;
      ack_d   = 1'b0;
      win_d   = WIN_NONE;
      rpt_d   = RPT_NONE;
      case (cmd_e'(cmd_q))
        CMD_ACCESS: begin
          if (has_q) begin
            if (bcast_q) begin
              start_d = 1'b1;
              len_d   = size_q;
              has_d   = 1'b0;
              win_d   = WIN_RESET;
            end else if (frag_w) begin
              send_d = 1'b1;
            end else begin
              start_d = 1'b1;
              len_d   = size_q;
              rts_d   = (size_q > rts_thr_q);
              ack_d   = 1'b1;
            end
          end
        end
        CMD_GOT_CTS: src_d = '0;
        CMD_MISS_CTS: begin
          if (has_q) begin
            src_d = src_inc;
            if (src_inc > RETRY_W'(max_short_q)) begin
              win_d = WIN_RESET;
              rpt_d = RPT_DROP;
              has_d = 1'b0;
            end else begin
              win_d = WIN_GROW;
            end
          end
        end
        CMD_GOT_ACK: begin
          lrc_d = '0;
          if (has_q && (!frag_w || last_w)) begin
            win_d = WIN_RESET;
            rpt_d = RPT_OK;
            has_d = 1'b0;
          end
        end
        CMD_MISS_ACK: begin
          if (has_q) begin
            lrc_d = lrc_inc;
            if (lrc_inc > RETRY_W'(max_long_q)) begin
              win_d = WIN_RESET;
              rpt_d = RPT_DROP;
              has_d = 1'b0;
            end else begin
              win_d = WIN_GROW;
              rpt_d = RPT_RETRY;
            end
          end
        end
        CMD_NEXT_FRAG: begin
          if (has_q && !bcast_q && frag_w && !last_w) begin
            fc_d   = fc_q + SIZE_BITS'(1);
            send_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Fragment fields from the (possibly advanced) fragment number.
  assign prod      = PW'(fc_q) * PW'(thr_eff);
  assign e_last    = (({1'b0, fc_q} + NW'(1)) >= n_q);
  assign e_next    = e_last ? '0 :
                     ((({1'b0, fc_q} + NW'(2)) == n_q) ? lastlen_q : thr_eff);
  assign out_busy_o = out_valid_q && !out_ready_i;
  assign emit_fire  = ctrl_i.emit && !out_busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rts_thr_q   <= SIZE_BITS'(RST_THRESHOLD);
      frag_thr_q  <= SIZE_BITS'(RST_THRESHOLD);
      max_short_q <= RST_MAX_SHORT;
      max_long_q  <= RST_MAX_LONG;
      has_q       <= 1'b0;
      size_q      <= '0;
      bcast_q     <= 1'b0;
      fc_q        <= '0;
      src_q       <= '0;
      lrc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RTS_THR:   rts_thr_q   <= cfg_data_i;
          CFG_FRAG_THR:  frag_thr_q  <= cfg_data_i;
          CFG_MAX_SHORT: max_short_q <= cfg_data_i[LIMIT_W-1:0];
          CFG_MAX_LONG:  max_long_q  <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      has_q   <= has_d;
      size_q  <= size_d;
      bcast_q <= bcast_d;
      fc_q    <= fc_d;
      src_q   <= src_d;
      lrc_q   <= lrc_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      cmd_q    <= in_cmd_i;
      qempty_q <= in_qempty_i;
      psize_q  <= in_psize_i;
      pbcast_q <= in_bcast_i;
    end
    deq_q   <= deq_d;
    send_q  <= send_d;
    start_q <= start_d;
    len_q   <= len_d;
    rts_q   <= rts_d;
    ack_q   <= ack_d;
    win_q   <= win_d;
    rpt_q   <= rpt_d;
    if (ctrl_i.decide) begin
      n_q       <= n_w;
      lastlen_q <= lastlen_w;
    end
    if (emit_fire) begin
      if (send_q) begin
        o_start_q <= 1'b1;
        o_off_q   <= prod[SIZE_BITS-1:0];
        o_len_q   <= e_last ? lastlen_q : thr_eff;
        o_idx_q   <= fc_q;
        o_more_q  <= !e_last;
        o_rts_q   <= 1'b0;
        o_ack_q   <= 1'b1;
        o_next_q  <= e_next;
      end else begin
        o_start_q <= start_q;
        o_off_q   <= '0;
        o_len_q   <= len_q;
        o_idx_q   <= '0;
        o_more_q  <= 1'b0;
        o_rts_q   <= rts_q;
        o_ack_q   <= ack_q;
        o_next_q  <= '0;
      end
      o_deq_q  <= deq_q;
      o_win_q  <= win_q;
      o_rpt_q  <= rpt_q;
      o_hold_q <= has_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_start_o       = o_start_q;
  assign tx_offset_o      = o_off_q;
  assign tx_length_o      = o_len_q;
  assign frag_index_o     = o_idx_q;
  assign more_frags_o     = o_more_q;
  assign use_rts_o        = o_rts_q;
  assign want_ack_o       = o_ack_q;
  assign next_frag_len_o  = o_next_q;
  assign dequeue_o        = o_deq_q;
  assign window_action_o  = o_win_q;
  assign report_o         = o_rpt_q;
  assign holding_packet_o = o_hold_q;

endmodule

// ===== hw/rtl/wifi_dcf_tx_retry_fragment_ctrl.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Transactions carry
// ----------+-----------+--------------------------------------------------
// s_axis    | in        | one MAC event (command in tuser, packet in tdata)
// m_axis    | out       | one result per event (transmit, window, report)
// cfg       | in        | one register write (index, data)
//
// Each event is accepted in the idle step and passes through the dequeue,
// divider init, divider iteration, decide and emit steps before its result
// is offered; the next event waits for the return to the idle step. The
// restoring divider works out one quotient bit per cycle. A new event is
// accepted only while the sequencer waits in its idle step. Reset (rst_ni,
// asynchronous, active low) clears the step counter, packet state and
// registers to their defaults. A result waiting on m_axis does not block the
// next event; the emit step of that next event waits for the output register
// to be free while m_axis stalls.

module wifi_dcf_tx_retry_fragment_ctrl #(
  parameter int unsigned SIZE_BITS = dcftx_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Event input.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: queue_empty, packet_size, dest_broadcast, zero fill.
  input  logic [((SIZE_BITS+2+7)/8)*8-1:0]  s_axis_tdata,
  // tuser from bit 0: command.
  input  logic [dcftx_pkg::CMD_W-1:0]       s_axis_tuser,
  // Result output.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: tx_start, tx_offset, tx_length, frag_index, more_frags,
  // use_rts, want_ack, next_frag_len, dequeue, window_action, report,
  // holding_packet, zero fill.
  output logic [((4*SIZE_BITS+10+7)/8)*8-1:0] m_axis_tdata,
  // Configuration write.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dcftx_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SIZE_BITS-1:0]              cfg_data_i
);
  import dcftx_pkg::*;

  localparam int unsigned OutW  = ((4 * SIZE_BITS + 10 + 7) / 8) * 8;

  uword_t               ctrl;
  seq_stat_t            stat;
  logic                 in_fire;
  logic                 div_last;
  logic                 out_busy;
  logic [SIZE_BITS-1:0] div_quo, div_rem, div_dividend, div_divisor;

  logic                 tx_start, more_frags, use_rts, want_ack, dequeue, holding;
  logic [SIZE_BITS-1:0] tx_offset, tx_length, frag_index, next_frag_len;
  win_e                 window_action;
  rpt_e                 report;

  // Registers are always writable; writes are expected only while idle.
  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  assign stat.in_fire  = in_fire;
  assign stat.div_last = div_last;
  assign stat.out_busy = out_busy;

  // Microcode sequencer: step counter plus control store.
  dcftx_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready)
  );

  // Fragment count comes from size / threshold, worked out one bit a cycle.
  dcftx_div #(
    .SIZE_BITS (SIZE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (ctrl.div_init),
    .step_i     (ctrl.div_step),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .last_o     (div_last)
  );

  // Packet state, retry counters, registers and the output register.
  dcftx_dp #(
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .in_fire_i        (in_fire),
    .in_cmd_i         (s_axis_tuser),
    .in_qempty_i      (s_axis_tdata[0]),
    .in_psize_i       (s_axis_tdata[SIZE_BITS:1]),
    .in_bcast_i       (s_axis_tdata[SIZE_BITS+1]),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i        (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i       (cfg_data_i),
    .div_quo_i        (div_quo),
    .div_rem_i        (div_rem),
    .div_dividend_o   (div_dividend),
    .div_divisor_o    (div_divisor),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_busy_o       (out_busy),
    .tx_start_o       (tx_start),
    .tx_offset_o      (tx_offset),
    .tx_length_o      (tx_length),
    .frag_index_o     (frag_index),
    .more_frags_o     (more_frags),
    .use_rts_o        (use_rts),
    .want_ack_o       (want_ack),
    .next_frag_len_o  (next_frag_len),
    .dequeue_o        (dequeue),
    .window_action_o  (window_action),
    .report_o         (report),
    .holding_packet_o (holding)
  );

  // Pack the result, lowest field first, zero filled to whole bytes.
  assign m_axis_tdata = OutW'({holding, report, window_action, dequeue, next_frag_len,
                               want_ack, use_rts, more_frags, frag_index, tx_length,
                               tx_offset, tx_start});

endmodule

// ===== hw/rtl/dcftx_chk.sv =====
`timescale 1ns / 1ps

module dcftx_chk #(
  parameter int unsigned SIZE_BITS = dcftx_pkg::SIZE_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((4*SIZE_BITS+10+7)/8)*8-1:0] m_axis_tdata
);
  import dcftx_pkg::*;

  localparam int unsigned S = SIZE_BITS;

  logic       tx_start, more_frags, use_rts, want_ack, holding;
  logic [S-1:0] tx_offset, tx_length, frag_index, next_len;
  logic [1:0] report;

  assign tx_start   = m_axis_tdata[0];
  assign tx_offset  = m_axis_tdata[S:1];
  assign tx_length  = m_axis_tdata[2*S:S+1];
  assign frag_index = m_axis_tdata[3*S:2*S+1];
  assign more_frags = m_axis_tdata[3*S+1];
  assign use_rts    = m_axis_tdata[3*S+2];
  assign want_ack   = m_axis_tdata[3*S+3];
  assign next_len   = m_axis_tdata[4*S+3:3*S+4];
  assign report     = m_axis_tdata[4*S+8:4*S+7];
  assign holding    = m_axis_tdata[4*S+9];

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // One event at a time: right after a transaction the input is closed.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second event taken while one is in progress");

  // Without a transmission all transmit fields are zero.
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !tx_start |-> tx_offset == '0 && tx_length == '0 &&
      frag_index == '0 && next_len == '0 && !more_frags && !use_rts && !want_ack)
    else $error("transmit fields set without a transmission");

  // Success or drop ends the packet.
  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (report == RPT_OK || report == RPT_DROP) |-> !holding)
    else $error("packet still held after completion");

  // A fragment with more to come names a nonzero next length.
  a_more_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && more_frags |-> tx_start && next_len != '0)
    else $error("more fragments flagged without a next fragment");

endmodule

bind wifi_dcf_tx_retry_fragment_ctrl dcftx_chk #(
  .SIZE_BITS (SIZE_BITS)
) u_dcftx_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
